[hw/rtl/i2a_pkg.sv]
package i2a_pkg;

  localparam int NUM_CELLS = 22;
  localparam int DIG_W     = 4;
  localparam int VAL_W     = 64;
  localparam int CNT_W     = $clog2(VAL_W);
  localparam int REM_W     = $clog2(NUM_CELLS + 1);

  localparam logic [1:0] FUNC_DEC    = 2'd0;
  localparam logic [1:0] FUNC_OCT    = 2'd1;
  localparam logic [1:0] FUNC_HEX_LO = 2'd2;
  localparam logic [1:0] FUNC_HEX_UP = 2'd3;

  localparam logic [1:0] SIZE_INT  = 2'd0;
  localparam logic [1:0] SIZE_LONG = 2'd1;

  localparam logic [6:0] CHAR_MINUS  = 7'h2D;
  localparam logic [6:0] CHAR_ZERO   = 7'h30;
  localparam logic [6:0] CHAR_LO_A   = 7'h61;
  localparam logic [6:0] CHAR_UP_A   = 7'h41;

  // Register index of long_is_wide
  localparam logic REG_LONG_IS_WIDE = 1'b0;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_LOAD   = 2'd1,
    OP_DABBLE = 2'd2,
    OP_SHIFT  = 2'd3
  } cell_op_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CONV = 5'b00010,
    S_SKIP = 5'b00100,
    S_SIGN = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  function automatic logic [6:0] digit_char(input logic [DIG_W-1:0] d, input logic upper);
    logic [6:0] base;
    begin
      base = upper ? CHAR_UP_A : CHAR_LO_A;
      if (d < 4'd10) digit_char = CHAR_ZERO + {3'b000, d};
      else digit_char = base + {3'b000, d - 4'd10};
    end
  endfunction

endpackage

[hw/rtl/integer_to_ascii_radix.sv]
// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall  func, operand_value, size_sel, as_unsigned
// out_      output     out_valid/out_stall char_out, last_char
// cfg       APB        psel/penable       long_is_wide at byte address 0
//
// One request at a time. Decimal: a load, then double-dabble shifts through the
// digit cell row, then leading-zero skip and emission; octal/hex load the cells directly.
// Skip shifts out leading zero digits, keeping at least one; emission gives one character per
// cycle while out_stall is low, after a minus sign for a negative decimal value.
// Synchronous active-low reset returns to idle, empties the output register and sets
// long_is_wide to 1. out_stall freezes emission; in_stall is high while a request is busy.
module integer_to_ascii_radix import i2a_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [63:0] in_operand_value,
  input  logic [1:0]  in_size_sel,
  input  logic        in_as_unsigned,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_char_out,
  output logic        out_last_char,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  state_t            state_r, state_nxt;
  logic              long_is_wide_r;
  logic [1:0]        func_r;
  logic              neg_r, neg_nxt;
  logic [VAL_W-1:0]  mag_r, mag_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [6:0]        out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;

  cell_op_t          op;
  logic              accept;
  logic              slot_free;
  logic              wide;
  logic [VAL_W-1:0]  val;
  logic [VAL_W+1:0]  val_ext;
  logic [DIG_W-1:0]  load_dig [NUM_CELLS];
  logic [DIG_W-1:0]  dig_q    [NUM_CELLS];
  logic              carry    [NUM_CELLS+1];
  logic [DIG_W-1:0]  top_dig;

  assign pready = 1'b1;
  assign prdata = {31'b0, long_is_wide_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_is_wide_r <= 1'b1;
    end else if (psel && penable && pwrite && paddr[2] == REG_LONG_IS_WIDE) begin
      long_is_wide_r <= pwdata[0];
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && (state_r == S_IDLE);
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    if (in_size_sel == SIZE_INT) wide = 1'b0;
    else if (in_size_sel == SIZE_LONG) wide = long_is_wide_r;
    else wide = 1'b1;
  end

  assign val     = wide ? in_operand_value : {32'b0, in_operand_value[31:0]};
  assign val_ext = {2'b00, val};

  always_comb begin
    for (int i = 0; i < NUM_CELLS; i++) begin
      if (in_func == FUNC_DEC) load_dig[i] = '0;
      else if (in_func == FUNC_OCT) load_dig[i] = {1'b0, val_ext[3*i +: 3]};
      else if (i < VAL_W / DIG_W) load_dig[i] = val[DIG_W*i +: DIG_W];
      else load_dig[i] = '0;
    end
  end

  assign carry[0] = mag_r[VAL_W-1];

  genvar g;
  generate
    for (g = 0; g < NUM_CELLS; g++) begin : g_cell
      i2a_cell u_cell (
        .clk        (clk),
        .op         (op),
        .load_digit (load_dig[g]),
        .bit_in     (carry[g]),
        .digit_in   ((g == 0) ? {DIG_W{1'b0}} : dig_q[(g == 0) ? 0 : g-1]),
        .bit_out    (carry[g+1]),
        .digit_q    (dig_q[g])
      );
    end
  endgenerate

  assign top_dig = dig_q[NUM_CELLS-1];

  always_comb begin
    state_nxt     = state_r;
    op            = OP_HOLD;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op      = OP_LOAD;
          rem_nxt = REM_W'(NUM_CELLS);
          cnt_nxt = '1;
          neg_nxt = 1'b0;
          mag_nxt = val;
          if (in_func == FUNC_DEC && !in_as_unsigned) begin
            if (wide) begin
              neg_nxt = val[VAL_W-1];
              if (val[VAL_W-1]) mag_nxt = -val;
            end else begin
              neg_nxt = val[31];
              if (val[31]) mag_nxt = {32'b0, -val[31:0]};
            end
          end
          state_nxt = (in_func == FUNC_DEC) ? S_CONV : S_SKIP;
        end
      end
      S_CONV: begin
        op      = OP_DABBLE;
        mag_nxt = {mag_r[VAL_W-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = S_SKIP;
      end
      S_SKIP: begin
        if (top_dig == '0 && rem_r != REM_W'(1)) begin
          op      = OP_SHIFT;
          rem_nxt = rem_r - 1'b1;
        end else begin
          state_nxt = neg_r ? S_SIGN : S_EMIT;
        end
      end
      S_SIGN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          op            = OP_SHIFT;
          out_valid_nxt = 1'b1;
          out_char_nxt  = digit_char(top_dig, func_r == FUNC_HEX_UP);
          out_last_nxt  = (rem_r == REM_W'(1));
          rem_nxt       = rem_r - 1'b1;
          if (rem_r == REM_W'(1)) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) func_r <= in_func;
    neg_r      <= neg_nxt;
    mag_r      <= mag_nxt;
    cnt_r      <= cnt_nxt;
    rem_r      <= rem_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_char_out  = out_char_r;
  assign out_last_char = out_last_r;

endmodule

[hw/rtl/i2a_cell.sv]
module i2a_cell import i2a_pkg::*; (
  input  logic             clk,
  input  cell_op_t         op,
  input  logic [DIG_W-1:0] load_digit,
  input  logic             bit_in,
  input  logic [DIG_W-1:0] digit_in,
  output logic             bit_out,
  output logic [DIG_W-1:0] digit_q
);

  logic [DIG_W-1:0] digit_r;
  logic [DIG_W-1:0] digit_nxt;
  logic [DIG_W-1:0] adj;

  // add-3 correction before the doubling shift
  assign adj     = (digit_r >= 4'd5) ? digit_r + 4'd3 : digit_r;
  assign bit_out = adj[DIG_W-1];
  assign digit_q = digit_r;

  always_comb begin
    case (op)
      OP_LOAD:   digit_nxt = load_digit;
      OP_DABBLE: digit_nxt = {adj[DIG_W-2:0], bit_in};
      OP_SHIFT:  digit_nxt = digit_in;
      default:   digit_nxt = digit_r;
    endcase
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule
